### sv/imte_pkg.sv
package imte_pkg;

    typedef logic [3:0] op_t;

    localparam op_t OP_SIZE  = 4'd0;
    localparam op_t OP_WRITE = 4'd1;
    localparam op_t OP_READ  = 4'd2;
    localparam op_t OP_SWAPC = 4'd3;
    localparam op_t OP_ROWS  = 4'd4;
    localparam op_t OP_COLS  = 4'd5;
    localparam op_t OP_REVR  = 4'd6;
    localparam op_t OP_REVC  = 4'd7;
    localparam op_t OP_DIAGS = 4'd8;
    localparam op_t OP_DIAGR = 4'd9;
    localparam op_t OP_MIRLR = 4'd10;
    localparam op_t OP_MIRTB = 4'd11;
    localparam op_t OP_TRANS = 4'd12;
    localparam op_t OP_ROT   = 4'd13;
    localparam op_t OP_NBR   = 4'd14;
    localparam op_t OP_NOP   = 4'd15;

    // loop counters and coordinates; one more bit than a size
    localparam int CW = 6;
    localparam int QDEPTH = 2;

    typedef struct packed {
        op_t        op;
        logic       ok;
        logic [3:0] ra;
        logic [3:0] ca;
        logic [3:0] rb;
        logic [3:0] cb;
        logic [4:0] dm;
        logic       neg;
        logic [4:0] rows;
        logic [4:0] cols;
        logic [7:0] pixel;
    } cmd_t;

endpackage

### sv/image_matrix_transform_engine_unit.sv
// channel | dir | tdata                                   | tuser
// s_*     | in  | row_a,col_a,row_b,col_b,diag,size_rows,  | req_type
//         |     | size_cols,pixel_in (40 bits)            |
// m_*     | out | pixel_out (8 bits)                      | ok
//
// Size and write go from the queue head through the loop state to the result word; read
// adds a pixel-store read state. Each cell swap runs the sequencer through the loop,
// read-B and two write states (two reads and two writes through the one read and one
// write port of the pixel store); rotate copies every cell to scratch and then back.
// Reset clears the size to zero; pixel store contents are undefined until written.
// Input stalls only when the two-entry command queue is full; output holds its word.
module image_matrix_transform_engine_unit import imte_pkg::*; #(
    parameter int MAX_DIM    = 16,
    parameter int PIXEL_BITS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // row_a, col_a, row_b, col_b, diag, size_rows, size_cols, pixel_in
    input  logic [3:0]  s_tuser,   // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // pixel_out
    output logic        m_tuser    // ok
);

    logic push, full, pop, empty;
    cmd_t cmd_in, cmd_head;

    imte_front #(.MAX_DIM(MAX_DIM)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .full     (full),
        .push     (push),
        .cmd      (cmd_in)
    );

    imte_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .cmd_in  (cmd_in),
        .full    (full),
        .pop     (pop),
        .cmd_out (cmd_head),
        .empty   (empty)
    );

    imte_back #(.MAX_DIM(MAX_DIM), .PIXEL_BITS(PIXEL_BITS)) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .empty    (empty),
        .head     (cmd_head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

### sv/imte_ram.sv
module imte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### sv/imte_front.sv
module imte_front import imte_pkg::*; #(
    parameter int MAX_DIM = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,
    input  logic [3:0]  s_tuser,
    input  logic        full,
    output logic        push,
    output cmd_t        cmd
);

    localparam logic [5:0] DIM_LIM = (MAX_DIM > 31) ? 6'd31 : 6'(MAX_DIM);

    logic [4:0] rows_reg, rows_next;
    logic [4:0] cols_reg, cols_next;
    logic [3:0] ra, ca, rb, cb;
    logic [4:0] dv, sr, sc, dm;
    logic       a_in, b_in, sq, dg_ok, sz_ok, nb_ok, ok;

    assign ra = s_tdata[3:0];
    assign ca = s_tdata[7:4];
    assign rb = s_tdata[11:8];
    assign cb = s_tdata[15:12];
    assign dv = s_tdata[20:16];
    assign sr = s_tdata[25:21];
    assign sc = s_tdata[30:26];

    assign s_tready = !full;
    assign push     = s_tvalid && !full;

    assign dm    = dv[4] ? 5'(5'd0 - dv) : dv;
    assign a_in  = ({1'b0, ra} < rows_reg) && ({1'b0, ca} < cols_reg);
    assign b_in  = ({1'b0, rb} < rows_reg) && ({1'b0, cb} < cols_reg);
    assign sq    = (rows_reg == cols_reg);
    assign dg_ok = sq && (dm < rows_reg);
    assign sz_ok = (sr != 5'd0) && ({1'b0, sr} <= DIM_LIM)
                && (sc != 5'd0) && ({1'b0, sc} <= DIM_LIM);
    assign nb_ok = (ra != 4'd0) && (({1'b0, ra} + 5'd1) < rows_reg)
                && (ca != 4'd0) && (({1'b0, ca} + 5'd1) < cols_reg)
                && (rb != 4'd0) && (({1'b0, rb} + 5'd1) < rows_reg)
                && (cb != 4'd0) && (({1'b0, cb} + 5'd1) < cols_reg);

    always_comb
    begin
        unique case (s_tuser)
            OP_SIZE:                     ok = sz_ok;
            OP_WRITE, OP_READ:           ok = a_in;
            OP_SWAPC:                    ok = a_in && b_in;
            OP_ROWS:                     ok = ({1'b0, ra} < rows_reg) && ({1'b0, rb} < rows_reg);
            OP_COLS:                     ok = ({1'b0, ca} < cols_reg) && ({1'b0, cb} < cols_reg);
            OP_REVR:                     ok = ({1'b0, ra} < rows_reg);
            OP_REVC:                     ok = ({1'b0, ca} < cols_reg);
            OP_DIAGS, OP_DIAGR:          ok = dg_ok;
            OP_MIRLR, OP_MIRTB, OP_ROT:  ok = 1'b1;
            OP_TRANS:                    ok = sq;
            OP_NBR:                      ok = nb_ok;
            default:                     ok = 1'b0;
        endcase
    end

    always_comb
    begin
        cmd.op    = s_tuser;
        cmd.ok    = ok;
        cmd.ra    = ra;
        cmd.ca    = ca;
        cmd.rb    = rb;
        cmd.cb    = cb;
        cmd.dm    = dm;
        cmd.neg   = dv[4];
        cmd.rows  = rows_reg;
        cmd.cols  = cols_reg;
        cmd.pixel = s_tdata[38:31];
    end

    // shadow of the image size as seen after all queued commands
    always_comb
    begin
        rows_next = rows_reg;
        cols_next = cols_reg;
        if (push && s_tuser == OP_SIZE && sz_ok)
        begin
            rows_next = sr;
            cols_next = sc;
        end
        else if (push && s_tuser == OP_ROT)
        begin
            rows_next = cols_reg;
            cols_next = rows_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= 5'd0;
            cols_reg <= 5'd0;
        end
        else
        begin
            rows_reg <= rows_next;
            cols_reg <= cols_next;
        end
    end

endmodule

### sv/imte_fifo.sv
module imte_fifo import imte_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t cmd_in,
    output logic full,
    input  logic pop,
    output cmd_t cmd_out,
    output logic empty
);

    localparam int PW = $clog2(QDEPTH);

    cmd_t            entry_reg [QDEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]     count_reg, count_next;

    assign full    = (count_reg == (PW+1)'(QDEPTH));
    assign empty   = (count_reg == '0);
    assign cmd_out = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full && !pop))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("queue read while empty");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (PW+1)'(QDEPTH))
        else $error("queue count out of range");

endmodule

### sv/imte_back.sv
module imte_back import imte_pkg::*; #(
    parameter int MAX_DIM    = 16,
    parameter int PIXEL_BITS = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       empty,
    input  cmd_t       head,
    output logic       pop,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic       m_tuser
);

    localparam int CELLS = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(CELLS);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_LOOP = 8'b0000_0010,
        S_RDB  = 8'b0000_0100,
        S_WRA  = 8'b0000_1000,
        S_WRB  = 8'b0001_0000,
        S_COPY = 8'b0010_0000,
        S_READ = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } state_t;

    state_t                state_reg, state_next;
    cmd_t                  cmd_reg;
    logic [CW-1:0]         o_reg, o_next, i_reg, i_next;
    logic                  ph_reg, ph_next;
    logic [PIXEL_BITS-1:0] tmp_reg;
    logic [7:0]            pix_reg;
    logic                  m_valid_reg, m_ok_reg;
    logic [7:0]            m_pix_reg;

    logic [CW-1:0] r6, c6, ra6, ca6, rb6, cb6, dm6, nd;
    logic [CW-1:0] outer, inner, r1, c1, r2, c2, k;
    logic [AW-1:0] addr_a, addr_b;

    logic                  st_we, sc_we;
    logic [AW-1:0]         st_waddr, st_raddr;
    logic [PIXEL_BITS-1:0] st_wdata, st_q, sc_q;
    logic                  load_out;

    imte_ram #(.WIDTH(PIXEL_BITS), .DEPTH(CELLS)) u_store (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (st_raddr),
        .rdata (st_q)
    );

    imte_ram #(.WIDTH(PIXEL_BITS), .DEPTH(CELLS)) u_scratch (
        .clk   (clk),
        .we    (sc_we),
        .waddr (addr_a),
        .wdata (st_q),
        .raddr (addr_b),
        .rdata (sc_q)
    );

    assign r6  = {1'b0, cmd_reg.rows};
    assign c6  = {1'b0, cmd_reg.cols};
    assign ra6 = {2'b0, cmd_reg.ra};
    assign ca6 = {2'b0, cmd_reg.ca};
    assign rb6 = {2'b0, cmd_reg.rb};
    assign cb6 = {2'b0, cmd_reg.cb};
    assign dm6 = {1'b0, cmd_reg.dm};
    assign nd  = r6 - dm6;
    assign k   = nd - 6'd1 - i_reg;

    // loop bounds
    always_comb
    begin
        outer = 6'd1;
        inner = 6'd1;
        case (cmd_reg.op)
            OP_ROWS:  inner = c6;
            OP_COLS:  inner = r6;
            OP_REVR:  inner = c6 >> 1;
            OP_REVC:  inner = r6 >> 1;
            OP_DIAGS: inner = nd;
            OP_DIAGR: inner = nd >> 1;
            OP_MIRLR:
            begin
                outer = r6;
                inner = c6 >> 1;
            end
            OP_MIRTB:
            begin
                outer = c6;
                inner = r6 >> 1;
            end
            OP_TRANS:
            begin
                outer = r6;
                inner = r6;
            end
            OP_NBR:
            begin
                outer = 6'd4;
                inner = (o_reg == 6'd3) ? 6'd1 : 6'd3;
            end
            OP_ROT:
            begin
                outer = ph_reg ? c6 : r6;
                inner = ph_reg ? r6 : c6;
            end
            default:
            begin
                outer = 6'd1;
                inner = 6'd1;
            end
        endcase
    end

    // cell pair for the current step
    always_comb
    begin
        r1 = ra6;
        c1 = ca6;
        r2 = rb6;
        c2 = cb6;
        case (cmd_reg.op)
            OP_ROWS:
            begin
                c1 = i_reg;
                c2 = i_reg;
            end
            OP_COLS:
            begin
                r1 = i_reg;
                r2 = i_reg;
            end
            OP_REVR:
            begin
                c1 = i_reg;
                r2 = ra6;
                c2 = c6 - 6'd1 - i_reg;
            end
            OP_REVC:
            begin
                r1 = i_reg;
                r2 = r6 - 6'd1 - i_reg;
                c2 = ca6;
            end
            OP_DIAGS:
            begin
                r1 = i_reg;
                c1 = i_reg + dm6;
                r2 = i_reg + dm6;
                c2 = i_reg;
            end
            OP_DIAGR:
            begin
                if (cmd_reg.neg)
                begin
                    r1 = i_reg + dm6;
                    c1 = i_reg;
                    r2 = k + dm6;
                    c2 = k;
                end
                else
                begin
                    r1 = i_reg;
                    c1 = i_reg + dm6;
                    r2 = k;
                    c2 = k + dm6;
                end
            end
            OP_MIRLR:
            begin
                r1 = o_reg;
                c1 = i_reg;
                r2 = o_reg;
                c2 = c6 - 6'd1 - i_reg;
            end
            OP_MIRTB:
            begin
                r1 = i_reg;
                c1 = o_reg;
                r2 = r6 - 6'd1 - i_reg;
                c2 = o_reg;
            end
            OP_TRANS:
            begin
                r1 = o_reg;
                c1 = i_reg;
                r2 = i_reg;
                c2 = o_reg;
            end
            OP_NBR:
            begin
                if (o_reg != 6'd3)
                begin
                    r1 = ra6 - 6'd1 + i_reg;
                    c1 = ca6 - 6'd1 + o_reg;
                    r2 = rb6 - 6'd1 + i_reg;
                    c2 = cb6 - 6'd1 + o_reg;
                end
            end
            OP_ROT:
            begin
                r1 = o_reg;
                c1 = i_reg;
                r2 = r6 - 6'd1 - i_reg;
                c2 = o_reg;
            end
            default:
            begin
                r1 = ra6;
                c1 = ca6;
                r2 = rb6;
                c2 = cb6;
            end
        endcase
    end

    assign addr_a = AW'(int'(r1) * MAX_DIM + int'(c1));
    assign addr_b = AW'(int'(r2) * MAX_DIM + int'(c2));

    assign load_out = (state_reg == S_DONE) && (!m_valid_reg || m_tready);
    assign pop      = (state_reg == S_IDLE) && !empty;
    assign sc_we    = (state_reg == S_COPY) && !ph_reg;

    always_comb
    begin
        st_raddr = (state_reg == S_RDB) ? addr_b : addr_a;
        st_we    = 1'b0;
        st_waddr = addr_a;
        st_wdata = st_q;
        unique case (state_reg)
            S_LOOP:
            begin
                st_we    = (cmd_reg.op == OP_WRITE);
                st_wdata = PIXEL_BITS'(cmd_reg.pixel);
            end
            S_WRA: st_we = 1'b1;
            S_WRB:
            begin
                st_we    = 1'b1;
                st_waddr = addr_b;
                st_wdata = tmp_reg;
            end
            S_COPY:
            begin
                st_we    = ph_reg;
                st_wdata = sc_q;
            end
            default: st_we = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        o_next     = o_reg;
        i_next     = i_reg;
        ph_next    = ph_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (!empty)
                begin
                    state_next = head.ok ? S_LOOP : S_DONE;
                    o_next     = '0;
                    i_next     = (head.op == OP_TRANS) ? 6'd1 : 6'd0;
                    ph_next    = 1'b0;
                end
            end
            S_LOOP:
            begin
                if (cmd_reg.op == OP_SIZE || cmd_reg.op == OP_WRITE)
                begin
                    state_next = S_DONE;
                end
                else if (cmd_reg.op == OP_READ)
                begin
                    state_next = S_READ;
                end
                else if (o_reg >= outer)
                begin
                    if (cmd_reg.op == OP_ROT && !ph_reg)
                    begin
                        ph_next = 1'b1;
                        o_next  = '0;
                        i_next  = '0;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else if (i_reg >= inner)
                begin
                    o_next = o_reg + 6'd1;
                    i_next = (cmd_reg.op == OP_TRANS) ? o_reg + 6'd2 : 6'd0;
                end
                else
                begin
                    state_next = (cmd_reg.op == OP_ROT) ? S_COPY : S_RDB;
                end
            end
            S_RDB: state_next = S_WRA;
            S_WRA: state_next = S_WRB;
            S_WRB:
            begin
                state_next = S_LOOP;
                i_next     = i_reg + 6'd1;
            end
            S_COPY:
            begin
                state_next = S_LOOP;
                i_next     = i_reg + 6'd1;
            end
            S_READ: state_next = S_DONE;
            S_DONE:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cmd_reg <= head;
            pix_reg <= 8'd0;
        end
        if (state_reg == S_RDB)
        begin
            tmp_reg <= st_q;
        end
        if (state_reg == S_READ)
        begin
            pix_reg <= 8'(st_q);
        end
        if (load_out)
        begin
            m_ok_reg  <= cmd_reg.ok;
            m_pix_reg <= pix_reg;
        end
        o_reg  <= o_next;
        i_reg  <= i_next;
        ph_reg <= ph_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_pix_reg;
    assign m_tuser  = m_ok_reg;

    a_scratch_rot: assert property (@(posedge clk) disable iff (!rst_n)
        sc_we |-> (cmd_reg.op == OP_ROT))
        else $error("scratch written outside rotation");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> (m_valid_reg && state_reg == S_IDLE))
        else $error("result load lost");

    a_rejected_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOOP) |-> cmd_reg.ok)
        else $error("rejected command reached the sequencer");

endmodule
